[sv/unique_value_set_table_unit_assert.svh]
// ----------------------------------------------------------------------------
// assertion macros for the value set table
// shared forms for the concurrent checks used in the rtl
// ----------------------------------------------------------------------------
`ifndef UNIQUE_VALUE_SET_TABLE_UNIT_ASSERT_SVH
`define UNIQUE_VALUE_SET_TABLE_UNIT_ASSERT_SVH

// same-cycle implication, disabled in reset
`define UVST_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled in reset
`define UVST_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[sv/uvst_pkg.sv]
// ----------------------------------------------------------------------------
// uvst_pkg
// shared types and constants of the value set table
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package uvst_pkg;

   localparam int CMD_W         = 2;
   localparam int VALUE_W       = 32;
   localparam int ENTRY_COUNT_W = 6;

   // operation codes; the unused code behaves as a query
   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT = 2'd0,
      CMD_DELETE = 2'd1,
      CMD_QUERY  = 2'd2
   } cmd_type;

   // sequencer states, one-hot
   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SCAN  = 4'b0010,
      ST_SHIFT = 4'b0100,
      ST_RESP  = 4'b1000
   } state_type;

   // memory port control from the sequencer
   typedef struct packed {
      logic rd_en;
      logic wr_en;
      logic wr_from_ram;
   } ram_ctl_type;

   // result flags from the sequencer
   typedef struct packed {
      logic done;
      logic was_present;
      logic full_refused;
   } seq_result_type;

endpackage

[sv/uvst_ram.sv]
// ----------------------------------------------------------------------------
// uvst_ram
// generic single write, single read memory with registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module uvst_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/uvst_seq.sv]
// ----------------------------------------------------------------------------
// uvst_seq
// sequencer: scans the list one entry a cycle, appends a new value on insert
// when room remains and closes the gap on delete with a read-ahead move loop
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "unique_value_set_table_unit_assert.svh"

module uvst_seq
   import uvst_pkg::*;
#(
   parameter int CAPACITY = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_accept,
   input  logic [CMD_W-1:0]            cmd,
   input  logic                        rd_match,
   input  logic                        slot_free,
   output logic                        idle,
   output ram_ctl_type                 ram_ctl,
   output logic [$clog2(CAPACITY)-1:0] rd_addr,
   output logic [$clog2(CAPACITY)-1:0] wr_addr,
   output logic [$clog2(CAPACITY+1)-1:0] count,
   output seq_result_type              result
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   state_type       state_ff, state_in;
   logic [CW-1:0]   idx_ff, idx_in;
   logic            pend_ff, pend_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            present_ff, present_in;
   logic            refused_ff, refused_in;

   logic            more;
   logic            hit;
   logic            full;
   logic [CW-1:0]   dest;

   assign more = (idx_ff != count_ff);
   assign hit  = pend_ff && rd_match;
   assign full = (count_ff == CW'(CAPACITY));
   assign dest = idx_ff - CW'(2);

   // next state and memory control
   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      pend_in     = pend_ff;
      count_in    = count_ff;
      present_in  = present_ff;
      refused_in  = refused_ff;
      ram_ctl     = '0;
      wr_addr     = count_ff[AW-1:0];
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               idx_in     = '0;
               pend_in    = 1'b0;
               present_in = 1'b0;
               refused_in = 1'b0;
               state_in   = ST_SCAN;
            end
         end
         ST_SCAN: begin
            ram_ctl.rd_en = more;
            if (hit) begin
               present_in = 1'b1;
               pend_in    = 1'b0;
               if (cmd == CMD_DELETE) begin
                  state_in = ST_SHIFT;
               end else begin
                  state_in = ST_RESP;
               end
            end else if (!more) begin
               if (cmd == CMD_INSERT) begin
                  if (full) begin
                     refused_in = 1'b1;
                  end else begin
                     ram_ctl.wr_en = 1'b1;
                     count_in      = count_ff + CW'(1);
                  end
               end
               state_in = ST_RESP;
            end else begin
               idx_in  = idx_ff + CW'(1);
               pend_in = 1'b1;
            end
         end
         ST_SHIFT: begin
            // the entry read last cycle moves down to its new place
            ram_ctl.rd_en       = more;
            ram_ctl.wr_en       = pend_ff;
            ram_ctl.wr_from_ram = 1'b1;
            wr_addr             = dest[AW-1:0];
            if (more) begin
               idx_in  = idx_ff + CW'(1);
               pend_in = 1'b1;
            end else begin
               pend_in  = 1'b0;
               count_in = count_ff - CW'(1);
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      idx_ff     <= idx_in;
      present_ff <= present_in;
      refused_ff <= refused_in;
   end

   assign idle                = (state_ff == ST_IDLE);
   assign rd_addr             = idx_ff[AW-1:0];
   assign count               = count_ff;
   assign result.done         = (state_ff == ST_RESP);
   assign result.was_present  = present_ff;
   assign result.full_refused = refused_ff;

   `UVST_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(CAPACITY),
                    "count above capacity")
   `UVST_ASSERT_NOW(a_refused_full, clock, reset, state_ff == ST_RESP && refused_ff,
                    full && !present_ff, "refusal without full table")
   `UVST_ASSERT_NEXT(a_shift_dec, clock, reset, state_ff == ST_SHIFT && !more,
                     count_ff == $past(count_ff) - CW'(1), "delete did not drop count")
   `UVST_ASSERT_NOW(a_scan_range, clock, reset, state_ff == ST_SCAN || state_ff == ST_SHIFT,
                    idx_ff <= count_ff, "index past count")

endmodule

[sv/unique_value_set_table_unit.sv]
// ----------------------------------------------------------------------------
// unique_value_set_table_unit
// set of distinct 32-bit values held as a packed list in a memory
// ----------------------------------------------------------------------------
// channel   direction  ports
// req_      in         req_valid req_ready req_cmd req_value
// rsp_      out        rsp_valid rsp_ready rsp_was_present rsp_entry_count
//                      rsp_full_refused
//
// one request at a time; a query or insert scans the list from the front until
// the value is found or the list ends, and a delete then moves each entry above
// the removed one down by one place to close the gap
// the list is searched through the single memory read port, one entry a cycle
// reset clears the count and the sequencer; list contents need no clearing
// the result register lets the next request in while a result waits
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module unique_value_set_table_unit
   import uvst_pkg::*;
#(
   parameter int CAPACITY = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [CMD_W-1:0]         req_cmd,
   input  logic [VALUE_W-1:0]       req_value,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic                     rsp_was_present,
   output logic [ENTRY_COUNT_W-1:0] rsp_entry_count,
   output logic                     rsp_full_refused
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   logic                     req_accept;
   logic [CMD_W-1:0]         cmd_ff;
   logic [VALUE_W-1:0]       value_ff;
   logic                     idle;
   ram_ctl_type              ram_ctl;
   logic [AW-1:0]            rd_addr;
   logic [AW-1:0]            wr_addr;
   logic [VALUE_W-1:0]       rd_data;
   logic [VALUE_W-1:0]       wr_data;
   logic [CW-1:0]            count;
   seq_result_type           result;
   logic                     rd_match;
   logic                     slot_free;
   logic                     rsp_load;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     was_present_ff;
   logic [ENTRY_COUNT_W-1:0] entry_count_ff;
   logic                     full_refused_ff;

   assign req_ready  = idle;
   assign req_accept = req_valid && req_ready;

   // request capture
   always_ff @(posedge clock) begin
      if (req_accept) begin
         cmd_ff   <= req_cmd;
         value_ff <= req_value;
      end
   end

   // shared compare against the stored entry and write data select
   assign rd_match = (rd_data == value_ff);
   assign wr_data  = ram_ctl.wr_from_ram ? rd_data : value_ff;

   uvst_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_ctl.wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (ram_ctl.rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   uvst_seq #(
      .CAPACITY (CAPACITY)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_accept),
      .cmd        (cmd_ff),
      .rd_match   (rd_match),
      .slot_free  (slot_free),
      .idle       (idle),
      .ram_ctl    (ram_ctl),
      .rd_addr    (rd_addr),
      .wr_addr    (wr_addr),
      .count      (count),
      .result     (result)
   );

   // result register
   assign slot_free    = !rsp_valid_ff || rsp_ready;
   assign rsp_load     = result.done && slot_free;
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         was_present_ff  <= result.was_present;
         entry_count_ff  <= ENTRY_COUNT_W'(count);
         full_refused_ff <= result.full_refused;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_was_present  = was_present_ff;
   assign rsp_entry_count  = entry_count_ff;
   assign rsp_full_refused = full_refused_ff;

endmodule
